// ----- hw/rtl/wbs_pkg.sv -----
// wbs_pkg: shared constants, command codes and controller/datapath link types
// for the word break segmenter
// no dependencies
package wbs_pkg;

  // dictionary geometry
  localparam int MAX_WORDS    = 32;
  localparam int MAX_WORD_LEN = 16;

  localparam int SYM_W  = 8;
  localparam int IDX_W  = $clog2(MAX_WORDS);         // row address
  localparam int WC_W   = $clog2(MAX_WORDS + 1);     // word count, holds MAX_WORDS
  localparam int LANE_W = $clog2(MAX_WORD_LEN);      // character lane index
  localparam int LEN_W  = $clog2(MAX_WORD_LEN + 1);  // word length, holds MAX_WORD_LEN

  // request command codes
  localparam logic [1:0] CMD_CLEAR = 2'd0;
  localparam logic [1:0] CMD_DICT  = 2'd1;
  localparam logic [1:0] CMD_TEXT  = 2'd2;

  // one dictionary row or the text window, lane 0 first
  typedef logic [MAX_WORD_LEN-1:0][SYM_W-1:0] row_t;

  // controller to datapath
  typedef struct packed {
    logic clear;
    logic dict_wr;
    logic text_start;
    logic scan;
    logic commit;
  } ctl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_done;
  } dp_sts_t;

endpackage

// ----- hw/rtl/wbs_ctrl.sv -----
// wbs_ctrl: sequencing state machine and output handshake of the segmenter
// depends on wbs_pkg
module wbs_ctrl
  import wbs_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  logic [1:0]   cmd_i,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  output ctl_cmd_t     ctl_cmd_o,
  input  dp_sts_t      dp_sts_i
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_RESULT = 2'd2;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       in_fire;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;

  // next state and commands
  always_comb begin
    state_d   = state_q;
    ctl_cmd_o = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          case (cmd_i)
            CMD_CLEAR: ctl_cmd_o.clear = 1'b1;
            CMD_DICT:  ctl_cmd_o.dict_wr = 1'b1;
            CMD_TEXT: begin
              ctl_cmd_o.text_start = 1'b1;
              state_d = ST_SCAN;
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        ctl_cmd_o.scan = 1'b1;
        if (dp_sts_i.scan_done) begin
          state_d = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (!out_valid_q || out_ready_i) begin
          ctl_cmd_o.commit = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // output valid: set on commit, cleared when taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (ctl_cmd_o.commit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

`ifndef SYNTHESIS
  // a text request never yields a result in the very next cycle
  a_text_no_early: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && cmd_i == CMD_TEXT) |=> (state_q == ST_SCAN && !ctl_cmd_o.commit))
    else $error("text request committed too early");
  // a commit always presents a result next cycle
  a_commit_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_cmd_o.commit |=> out_valid_q)
    else $error("commit did not raise out_valid");
  // with an empty output stage the result state moves to idle in the cycle after
  a_result_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RESULT && !out_valid_q) |=> state_q == ST_IDLE)
    else $error("result stalled with free output stage");
`endif

endmodule

// ----- hw/rtl/wbs_datapath.sv -----
// wbs_datapath: dictionary memory, text window, reachability history,
// word scan compare and result registers
// depends on wbs_pkg
module wbs_datapath
  import wbs_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [SYM_W-1:0] symbol_i,
  input  logic             end_mark_i,
  input  ctl_cmd_t         ctl_cmd_i,
  output dp_sts_t          dp_sts_o,
  output logic             prefix_ok_o,
  output logic             text_end_o
);

  // dictionary storage, one row per word
  row_t             dict_mem [MAX_WORDS];
  logic [LEN_W-1:0] len_mem  [MAX_WORDS];

  logic [WC_W-1:0]  word_count_q, word_count_d;
  logic [LEN_W-1:0] load_len_q, load_len_d;
  logic [LEN_W-1:0] new_len;
  logic             dict_open;
  logic             char_wr;
  logic             word_close;

  row_t                    win_q;
  logic [MAX_WORD_LEN-1:0] reach_q;

  logic [WC_W-1:0]  idx_q;
  logic             issue;
  row_t             row_q;
  logic [LEN_W-1:0] len_q;
  logic             cmp_vld_q;
  logic             match;
  logic             hit_q;
  logic             last_q;
  logic             prefix_ok_q;
  logic             text_end_q;

  // dictionary load control
  assign dict_open  = (word_count_q < WC_W'(MAX_WORDS));
  assign char_wr    = ctl_cmd_i.dict_wr && dict_open && (load_len_q < LEN_W'(MAX_WORD_LEN));
  assign new_len    = char_wr ? load_len_q + LEN_W'(1) : load_len_q;
  assign word_close = ctl_cmd_i.dict_wr && dict_open && end_mark_i && (new_len != '0);

  always_comb begin
    word_count_d = word_count_q;
    load_len_d   = load_len_q;
    if (ctl_cmd_i.clear) begin
      word_count_d = '0;
      load_len_d   = '0;
    end else if (ctl_cmd_i.dict_wr && dict_open) begin
      load_len_d = end_mark_i ? '0 : new_len;
      if (word_close) begin
        word_count_d = word_count_q + WC_W'(1);
      end
    end
  end

  // scan issues one word row per cycle
  assign issue = ctl_cmd_i.scan && (idx_q < word_count_q);

  // memory write and registered read
  always_ff @(posedge clk_i) begin
    if (char_wr) begin
      dict_mem[word_count_q[IDX_W-1:0]][load_len_q[LANE_W-1:0]] <= symbol_i;
    end
    if (word_close) begin
      len_mem[word_count_q[IDX_W-1:0]] <= new_len;
    end
    if (issue) begin
      row_q <= dict_mem[idx_q[IDX_W-1:0]];
      len_q <= len_mem[idx_q[IDX_W-1:0]];
    end
  end

  // word versus newest characters, gated by reach of the prefix before it
  always_comb begin
    match = (len_q != '0) && reach_q[LANE_W'(len_q - LEN_W'(1))];
    for (int j = 0; j < MAX_WORD_LEN; j++) begin
      if (LEN_W'(j) < len_q) begin
        if (row_q[j] != win_q[LANE_W'(len_q - LEN_W'(j) - LEN_W'(1))]) begin
          match = 1'b0;
        end
      end
    end
  end

  // text window shift, no reset needed
  always_ff @(posedge clk_i) begin
    if (ctl_cmd_i.text_start) begin
      win_q <= {win_q[MAX_WORD_LEN-2:0], symbol_i};
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_count_q <= '0;
      load_len_q   <= '0;
      reach_q      <= MAX_WORD_LEN'(1);
      idx_q        <= '0;
      cmp_vld_q    <= 1'b0;
      hit_q        <= 1'b0;
      last_q       <= 1'b0;
    end else begin
      word_count_q <= word_count_d;
      load_len_q   <= load_len_d;
      if (ctl_cmd_i.text_start) begin
        idx_q     <= '0;
        cmp_vld_q <= 1'b0;
        hit_q     <= 1'b0;
        last_q    <= end_mark_i;
      end else if (ctl_cmd_i.scan) begin
        cmp_vld_q <= issue;
        if (issue) begin
          idx_q <= idx_q + WC_W'(1);
        end
        if (cmp_vld_q && match) begin
          hit_q <= 1'b1;
        end
      end
      if (ctl_cmd_i.commit) begin
        reach_q <= last_q ? MAX_WORD_LEN'(1) : {reach_q[MAX_WORD_LEN-2:0], hit_q};
      end
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (ctl_cmd_i.commit) begin
      prefix_ok_q <= hit_q;
      text_end_q  <= last_q;
    end
  end

  assign dp_sts_o.scan_done = !issue && !cmp_vld_q;
  assign prefix_ok_o        = prefix_ok_q;
  assign text_end_o         = text_end_q;

`ifndef SYNTHESIS
  a_wc_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    word_count_q <= WC_W'(MAX_WORDS))
    else $error("word count beyond dictionary size");
  a_len_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_len_q <= LEN_W'(MAX_WORD_LEN))
    else $error("open word longer than a row");
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_cmd_i.scan |-> idx_q <= word_count_q)
    else $error("scan index ran past stored words");
`endif

endmodule

// ----- hw/rtl/word_break_segmenter.sv -----
// word_break_segmenter: top level, controller plus datapath
// depends on wbs_pkg, wbs_ctrl, wbs_datapath
//
//   channel | handshake             | payload
//   --------+-----------------------+-------------------------------
//   in      | in_valid_i/in_ready_o | cmd_i, symbol_i, end_mark_i
//   out     | out_valid_o/out_ready_i | prefix_ok_o, text_end_o
//
// clear and dictionary requests give no result
// a text request scans the stored words; the scan reads one dictionary row
// per cycle from a single read port and compares all its characters at
// once, plus fill and drain of that read
// the output stage holds one result; a new request is taken while it waits
// reset is asynchronous, active low; empty dictionary, empty prefix reachable
module word_break_segmenter
  import wbs_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [1:0]       cmd_i,
  input  logic [SYM_W-1:0] symbol_i,
  input  logic             end_mark_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic             prefix_ok_o,
  output logic             text_end_o
);

  ctl_cmd_t ctl_cmd;
  dp_sts_t  dp_sts;

  wbs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .cmd_i       (cmd_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .ctl_cmd_o   (ctl_cmd),
    .dp_sts_i    (dp_sts)
  );

  wbs_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .symbol_i    (symbol_i),
    .end_mark_i  (end_mark_i),
    .ctl_cmd_i   (ctl_cmd),
    .dp_sts_o    (dp_sts),
    .prefix_ok_o (prefix_ok_o),
    .text_end_o  (text_end_o)
  );

endmodule
